FILE: rtl/tdpf_pkg.sv
package tdpf_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int ID_W = 32;
  localparam int TIME_W = 32;
  localparam int LIFE_W = 31;
  localparam logic [LIFE_W-1:0] LIFE_RESET = LIFE_W'(30000);

  typedef enum logic {
    CMD_CHECK = 1'b0,
    CMD_SWEEP = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   src;
    logic [ID_W-1:0]   frm;
    logic [TIME_W-1:0] exp;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  function automatic logic is_ahead(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

  function automatic logic is_behind(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d[TIME_W-1];
  endfunction

endpackage

FILE: rtl/tdpf_ram.sv
module tdpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/timed_duplicate_packet_filter.sv
// Duplicate filter for received packets, backed by a ring of seen slots.
// Input transaction: raise start with in_cmd, in_source_id, in_frame_number
// and in_now_ms while busy is low; it is taken at that clock edge.
// A check (in_cmd = 0) produces one result transaction on out_valid and
// out_is_duplicate; a sweep (in_cmd = 1) produces none.
// Every transaction walks the whole slot memory, one read per cycle through a
// single read port, with the modify and write-back in the cycle after the read.
// Busy stays high from the accept edge through the scan and drain states, so a
// new transaction can be taken only once the block is back in idle.
// The result of a check is registered from the drain state, is held for
// exactly one cycle, and the receiver cannot stall it.
// cfg_we writes the lifetime in milliseconds; the user must write it only
// while idle, and the block itself does not enforce this.
// Synchronous reset clears the write head, the per-slot valid flags and the
// controller; a slot never written since reset reads as all zero, so no
// clearing pass is needed and the block is ready right after reset.
module timed_duplicate_packet_filter
  import tdpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_cmd,
  input  logic [ID_W-1:0]   in_source_id,
  input  logic [ID_W-1:0]   in_frame_number,
  input  logic [TIME_W-1:0] in_now_ms,
  output logic              out_valid,
  output logic              out_is_duplicate,
  input  logic              cfg_we,
  input  logic [LIFE_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;
  logic [SLOT_AW-1:0] cnt_r, cnt_nxt;
  logic [SLOT_AW-1:0] head_r, head_nxt;
  logic [SLOT_AW-1:0] chk_addr_r;
  logic chk_vld_r, chk_vld_nxt;
  logic rd_valid_r;
  logic hit_r, hit_nxt;
  logic [SLOTS-1:0] valid_r;
  logic [LIFE_W-1:0] life_r;
  cmd_t cmd_r;
  logic [ID_W-1:0] src_r, frm_r;
  logic [TIME_W-1:0] now_r;
  logic out_valid_r, out_valid_nxt;
  logic out_dup_r, out_dup_nxt;

  logic accept;
  logic last_rd;
  slot_t rd_word, entry;
  logic cur_hit, hit_any;
  logic mem_we;
  logic [SLOT_AW-1:0] mem_waddr;
  slot_t mem_wdata;
  logic do_record, do_clear;

  assign accept = start && (state_r == ST_IDLE);
  assign busy = (state_r != ST_IDLE);
  assign last_rd = (cnt_r == SLOT_AW'(SLOTS - 1));

  tdpf_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(cnt_r),
    .rdata(rd_word)
  );

  assign entry = rd_valid_r ? rd_word : '0;
  assign cur_hit = chk_vld_r && (entry.src == src_r) && (entry.frm == frm_r) &&
                   is_ahead(entry.exp, now_r);
  assign hit_any = hit_r || cur_hit;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_rd) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    chk_vld_nxt = 1'b0;
    hit_nxt = hit_r;
    head_nxt = head_r;
    out_valid_nxt = 1'b0;
    out_dup_nxt = out_dup_r;
    do_clear = 1'b0;
    do_record = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        hit_nxt = 1'b0;
      end
      ST_SCAN: begin
        chk_vld_nxt = 1'b1;
        hit_nxt = hit_any;
        if (!last_rd) begin
          cnt_nxt = cnt_r + SLOT_AW'(1);
        end
        do_clear = (cmd_r == CMD_SWEEP) && chk_vld_r && (entry.src != '0) &&
                   is_behind(entry.exp, now_r);
      end
      ST_DRAIN: begin
        if (cmd_r == CMD_SWEEP) begin
          do_clear = (entry.src != '0) && is_behind(entry.exp, now_r);
        end else begin
          out_valid_nxt = 1'b1;
          out_dup_nxt = hit_any;
          do_record = !hit_any;
          if (!hit_any) begin
            head_nxt = (head_r == SLOT_AW'(SLOTS - 1)) ? '0 : head_r + SLOT_AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we = do_clear || do_record;
    mem_waddr = do_record ? head_r : chk_addr_r;
    if (do_record) begin
      mem_wdata.src = src_r;
      mem_wdata.frm = frm_r;
      mem_wdata.exp = now_r + {1'b0, life_r};
    end else begin
      mem_wdata.src = '0;
      mem_wdata.frm = '0;
      mem_wdata.exp = entry.exp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      head_r <= '0;
      chk_vld_r <= 1'b0;
      hit_r <= 1'b0;
      valid_r <= '0;
      life_r <= LIFE_RESET;
      out_valid_r <= 1'b0;
      out_dup_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      head_r <= head_nxt;
      chk_vld_r <= chk_vld_nxt;
      hit_r <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      out_dup_r <= out_dup_nxt;
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        life_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= cnt_r;
    rd_valid_r <= valid_r[cnt_r];
    if (accept) begin
      cmd_r <= cmd_t'(in_cmd);
      src_r <= in_source_id;
      frm_r <= in_frame_number;
      now_r <= in_now_ms;
    end
  end

  assign out_valid = out_valid_r;
  assign out_is_duplicate = out_dup_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy did not rise after an accepted transaction");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_DRAIN) && ($past(cmd_r) == CMD_CHECK))
    else $error("result strobe without a finished check");

  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != ST_IDLE))
    else $error("slot memory written while idle");

  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (head_r != $past(head_r))) |-> (out_valid_r && !out_dup_r))
    else $error("write head moved without a recorded packet");

endmodule
